FILE: rtl/rgb565_dither_mono_packer_defines.svh
// ----------------------------------------------------------------------------
// rgb565_dither_mono_packer assertion macros
// shared assertion forms for the checker of the mono packer
// ----------------------------------------------------------------------------
`ifndef RGB565_DITHER_MONO_PACKER_DEFINES_SVH
`define RGB565_DITHER_MONO_PACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RDMP_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rdmp check failed");

// next-cycle implication, sampled on clk, off during reset
`define RDMP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rdmp check failed");

`endif

FILE: rtl/rdmp_pkg.sv
// ----------------------------------------------------------------------------
// rdmp_pkg
// constants, codes and color helpers of the rgb565 mono packer
// ----------------------------------------------------------------------------
`default_nettype none

package rdmp_pkg;

    // frame store geometry
    localparam int unsigned STORE_BYTES = 8064;
    localparam int unsigned ADDR_W      = 13;

    // opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes
    localparam int unsigned  CFG_INDEX_W       = 3;
    localparam int unsigned  CFG_DATA_W        = 11;
    localparam logic [2:0]   CFG_DITHER_MODE   = 3'd0;
    localparam logic [2:0]   CFG_ORIGIN_X      = 3'd1;
    localparam logic [2:0]   CFG_ORIGIN_Y      = 3'd2;
    localparam logic [2:0]   CFG_WINDOW_WIDTH  = 3'd3;
    localparam logic [2:0]   CFG_WINDOW_HEIGHT = 3'd4;

    // register reset values and the window counter limit
    localparam logic [9:0] WIDTH_RESET  = 10'd384;
    localparam logic [9:0] HEIGHT_RESET = 10'd168;
    localparam logic [9:0] COUNT_MAX    = 10'd512;

    // luminance weights and fixed threshold
    localparam logic [7:0] LUM_R          = 8'd54;
    localparam logic [7:0] LUM_G          = 8'd183;
    localparam logic [7:0] LUM_B          = 8'd19;
    localparam logic [7:0] MONO_THRESHOLD = 8'd128;

    // c * 255 / 31 as 8c + floor(7c / 31)
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [2:0] frac;
        frac = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
             + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
        return {c, 3'b000} + {5'b00000, frac};
    endfunction

    // g * 255 / 63 as 4g + floor(g / 21)
    function automatic logic [7:0] expand6(input logic [5:0] g);
        logic [1:0] frac;
        frac = 2'(g >= 6'd21) + 2'(g >= 6'd42) + 2'(g >= 6'd63);
        return {g, 2'b00} + {6'b000000, frac};
    endfunction

    // standard 4x4 bayer matrix, index {row[1:0], col[1:0]}
    function automatic logic [3:0] bayer(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd8;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd10;
            4'd4:    v = 4'd12;
            4'd5:    v = 4'd4;
            4'd6:    v = 4'd14;
            4'd7:    v = 4'd6;
            4'd8:    v = 4'd3;
            4'd9:    v = 4'd11;
            4'd10:   v = 4'd1;
            4'd11:   v = 4'd9;
            4'd12:   v = 4'd15;
            4'd13:   v = 4'd7;
            4'd14:   v = 4'd13;
            4'd15:   v = 4'd5;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rgb565_dither_mono_packer.sv
// ----------------------------------------------------------------------------
// rgb565_dither_mono_packer
// rgb565 blit pixels to a packed 1 bit per pixel frame store, bayer dither
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while in_stall is low: pixel
// transactions of a blit window in raster order and byte read transactions,
// in any mix. Each transaction gives exactly one result, in the order of
// acceptance. The result passes through four pipeline stages and the
// output register, five transactions deep. The limit of one per cycle is
// set by the frame store ram, which does one read and one write of a byte
// per cycle; back-to-back updates of the same byte are forwarded from the
// last write. After reset the frame store is cleared one byte a cycle, all
// 8064 bytes, with in_stall held high; configuration writes are taken at
// any time (cfg_ready stays high) but must only be made while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_dither_mono_packer #(
    parameter int unsigned PANEL_COLUMNS       = 168,
    parameter int unsigned PANEL_LINES         = 384,
    parameter int unsigned BYTES_PER_LINE_PAIR = 42
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [15:0] pixel_color,
    input  wire logic [12:0] read_index,
    // result transactions
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [12:0] store_index,
    output logic      [7:0]  byte_value,
    output logic             pixel_written,
    output logic             window_done,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int unsigned AW = rdmp_pkg::ADDR_W;

    // panel geometry in the widths the datapath uses
    localparam logic [10:0] LINES_LIM = 11'(PANEL_LINES);
    localparam logic [10:0] COLS_LIM  = 11'(PANEL_COLUMNS);
    localparam logic [8:0]  PX_LAST   = 9'(PANEL_COLUMNS - 1);
    localparam logic [16:0] BPLP      = 17'(BYTES_PER_LINE_PAIR);
    localparam logic [16:0] STORE_LIM = 17'(rdmp_pkg::STORE_BYTES);
    localparam logic [12:0] LAST_ADDR = 13'(rdmp_pkg::STORE_BYTES - 1);

    // stage 1: logical position and window bookkeeping
    typedef struct packed {
        logic        op;
        logic [15:0] color;
        logic [12:0] read_index;
        logic [9:0]  lx;
        logic [8:0]  ly;
        logic        in_panel;
        logic        done;
    } s1_t;

    // stage 2: expanded channels, threshold, byte coordinates
    typedef struct packed {
        logic        op;
        logic [12:0] read_index;
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        logic [7:0]  thr;
        logic [16:0] line_base;
        logic [6:0]  col_byte;
        logic [2:0]  bit_sel;
        logic        in_panel;
        logic        done;
    } s2_t;

    // stages 3 and 4: store access
    typedef struct packed {
        logic        op;
        logic [12:0] addr;
        logic        addr_ok;
        logic        dark;
        logic [2:0]  bit_sel;
        logic        done;
    } s3_t;

    // configuration registers
    logic        dither_mode_reg;
    logic [10:0] origin_x_reg;
    logic [10:0] origin_y_reg;
    logic [9:0]  window_width_reg;
    logic [9:0]  window_height_reg;

    // window counters
    logic [8:0]  column_count_reg;
    logic [8:0]  column_count_next;
    logic [8:0]  row_count_reg;
    logic [8:0]  row_count_next;

    // store clearing pass
    logic        clearing_reg;
    logic [12:0] clear_addr_reg;

    // pipeline
    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    logic        s4_valid_reg;
    s1_t         s1_reg;
    s1_t         s1_next;
    s2_t         s2_reg;
    s2_t         s2_next;
    s3_t         s3_reg;
    s3_t         s3_next;
    s3_t         s4_reg;

    // last store write, for read-after-write forwarding
    logic        fwd_valid_reg;
    logic [12:0] fwd_addr_reg;
    logic [7:0]  fwd_data_reg;

    // output register
    logic        out_valid_reg;
    logic [12:0] store_index_reg;
    logic [12:0] store_index_next;
    logic [7:0]  byte_value_reg;
    logic [7:0]  byte_value_next;
    logic        pixel_written_reg;
    logic        pixel_written_next;
    logic        window_done_reg;

    // flow control
    logic        out_ready;
    logic        s4_en;
    logic        s3_en;
    logic        s2_en;
    logic        s1_en;
    logic        in_fire;
    logic        pixel_fire;

    // stage 0 signals
    logic [11:0] lx;
    logic [11:0] ly;
    logic [9:0]  eff_width;
    logic [9:0]  eff_height;
    logic        col_wrap;
    logic        row_wrap;

    // stage 1 to 2 signals
    logic [8:0]  px;
    logic [9:0]  py;

    // stage 2 to 3 signals
    logic [15:0] lum_sum;
    logic [16:0] pix_idx;
    logic        pix_ok;

    // stage 4 signals
    logic [7:0]  rd_data;
    logic [7:0]  cur_byte;
    logic [7:0]  bit_mask;
    logic [7:0]  new_byte;
    logic        store_write;
    logic        ram_we;
    logic [12:0] ram_waddr;
    logic [7:0]  ram_wdata;
    logic [12:0] ram_raddr;

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------

    // each stage loads when empty or when its content moves on
    assign out_ready  = !out_valid_reg || !out_stall;
    assign s4_en      = !s4_valid_reg || out_ready;
    assign s3_en      = !s3_valid_reg || s4_en;
    assign s2_en      = !s2_valid_reg || s3_en;
    assign s1_en      = !s1_valid_reg || s2_en;

    assign in_stall   = clearing_reg || !s1_en;
    assign in_fire    = in_valid && !in_stall;
    assign pixel_fire = in_fire && (opcode == rdmp_pkg::OP_PIXEL);

    assign cfg_ready  = 1'b1;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_mode_reg   <= 1'b0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            window_width_reg  <= rdmp_pkg::WIDTH_RESET;
            window_height_reg <= rdmp_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rdmp_pkg::CFG_DITHER_MODE:   dither_mode_reg   <= cfg_data[0];
                rdmp_pkg::CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                rdmp_pkg::CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                rdmp_pkg::CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[9:0];
                rdmp_pkg::CFG_WINDOW_HEIGHT: window_height_reg <= cfg_data[9:0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: position of the accepted pixel, counter advance
    // ------------------------------------------------------------------------

    // origin plus counter, 12 bit two's complement
    assign lx = {origin_x_reg[10], origin_x_reg} + {3'b000, column_count_reg};
    assign ly = {origin_y_reg[10], origin_y_reg} + {3'b000, row_count_reg};

    // zero size acts as one, oversize acts as the counter limit
    always_comb
    begin
        eff_width  = window_width_reg;
        eff_height = window_height_reg;
        if (window_width_reg == 10'd0)
        begin
            eff_width = 10'd1;
        end
        else if (window_width_reg > rdmp_pkg::COUNT_MAX)
        begin
            eff_width = rdmp_pkg::COUNT_MAX;
        end
        if (window_height_reg == 10'd0)
        begin
            eff_height = 10'd1;
        end
        else if (window_height_reg > rdmp_pkg::COUNT_MAX)
        begin
            eff_height = rdmp_pkg::COUNT_MAX;
        end
    end

    // a counter left beyond the size wraps as if on the last position
    assign col_wrap = ({1'b0, column_count_reg} + 10'd1) >= eff_width;
    assign row_wrap = ({1'b0, row_count_reg} + 10'd1) >= eff_height;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (pixel_fire)
        begin
            if (col_wrap)
            begin
                column_count_next = '0;
                row_count_next    = row_wrap ? 9'd0 : row_count_reg + 9'd1;
            end
            else
            begin
                column_count_next = column_count_reg + 9'd1;
            end
        end
    end

    always_comb
    begin
        s1_next.op         = opcode;
        s1_next.color      = pixel_color;
        s1_next.read_index = read_index;
        s1_next.lx         = lx[9:0];
        s1_next.ly         = ly[8:0];
        // logical y runs along panel columns, logical x along panel lines
        s1_next.in_panel   = !lx[11] && (lx[10:0] < LINES_LIM)
                          && !ly[11] && (ly[10:0] < COLS_LIM);
        s1_next.done       = (opcode == rdmp_pkg::OP_PIXEL) && col_wrap && row_wrap;
    end

    // ------------------------------------------------------------------------
    // stage 1: channel expansion, threshold, rotation into panel coordinates
    // ------------------------------------------------------------------------

    assign px = PX_LAST - s1_reg.ly;
    assign py = s1_reg.lx;

    always_comb
    begin
        s2_next.op         = s1_reg.op;
        s2_next.read_index = s1_reg.read_index;
        s2_next.r8         = rdmp_pkg::expand5(s1_reg.color[15:11]);
        s2_next.g8         = rdmp_pkg::expand6(s1_reg.color[10:5]);
        s2_next.b8         = rdmp_pkg::expand5(s1_reg.color[4:0]);
        if (dither_mode_reg)
        begin
            // bayer value * 16 + 8
            s2_next.thr = {rdmp_pkg::bayer({s1_reg.ly[1:0], s1_reg.lx[1:0]}), 4'b1000};
        end
        else
        begin
            s2_next.thr = rdmp_pkg::MONO_THRESHOLD;
        end
        // two panel lines per byte row, four panel columns per byte
        s2_next.line_base  = {8'b0000_0000, py[9:1]} * BPLP;
        s2_next.col_byte   = px[8:2];
        // bit 7 - (2 * (px % 4) + py % 2)
        s2_next.bit_sel    = ~{px[1:0], py[0]};
        s2_next.in_panel   = s1_reg.in_panel;
        s2_next.done       = s1_reg.done;
    end

    // ------------------------------------------------------------------------
    // stage 2: luminance compare, byte address
    // ------------------------------------------------------------------------

    assign lum_sum = ({8'b0000_0000, s2_reg.r8} * {8'b0000_0000, rdmp_pkg::LUM_R})
                   + ({8'b0000_0000, s2_reg.g8} * {8'b0000_0000, rdmp_pkg::LUM_G})
                   + ({8'b0000_0000, s2_reg.b8} * {8'b0000_0000, rdmp_pkg::LUM_B});

    assign pix_idx = s2_reg.line_base + {10'b00_0000_0000, s2_reg.col_byte};
    assign pix_ok  = s2_reg.in_panel && (pix_idx < STORE_LIM);

    always_comb
    begin
        s3_next.op      = s2_reg.op;
        s3_next.dark    = lum_sum[15:8] < s2_reg.thr;
        s3_next.bit_sel = s2_reg.bit_sel;
        s3_next.done    = s2_reg.done;
        if (s2_reg.op == rdmp_pkg::OP_READ)
        begin
            s3_next.addr    = s2_reg.read_index;
            s3_next.addr_ok = {4'b0000, s2_reg.read_index} < STORE_LIM;
        end
        else
        begin
            // clipped pixels report byte index zero
            s3_next.addr    = pix_ok ? pix_idx[AW-1:0] : '0;
            s3_next.addr_ok = pix_ok;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3 to 4: store read, stage 4: modify and write back
    // ------------------------------------------------------------------------

    // out of range reads go to a harmless address, the result is masked
    assign ram_raddr = s3_reg.addr_ok ? s3_reg.addr : '0;

    // the write of the same edge as this read is not in rd_data yet
    assign cur_byte = (fwd_valid_reg && (fwd_addr_reg == s4_reg.addr)) ? fwd_data_reg : rd_data;
    assign bit_mask = 8'b0000_0001 << s4_reg.bit_sel;
    assign new_byte = s4_reg.dark ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);

    assign store_write = s4_valid_reg && out_ready
                      && (s4_reg.op == rdmp_pkg::OP_PIXEL) && s4_reg.addr_ok;

    // clearing pass owns the write port until done
    assign ram_we    = clearing_reg || store_write;
    assign ram_waddr = clearing_reg ? clear_addr_reg : s4_reg.addr;
    assign ram_wdata = clearing_reg ? 8'h00 : new_byte;

    rdmp_ram #(
        .WIDTH (8),
        .DEPTH (rdmp_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s4_en),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        store_index_next   = s4_reg.addr;
        pixel_written_next = 1'b0;
        byte_value_next    = 8'h00;
        if (s4_reg.addr_ok)
        begin
            if (s4_reg.op == rdmp_pkg::OP_READ)
            begin
                byte_value_next = cur_byte;
            end
            else
            begin
                byte_value_next    = new_byte;
                pixel_written_next = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            clearing_reg     <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            if (clearing_reg)
            begin
                if (clear_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
                clear_addr_reg <= clear_addr_reg + 13'd1;
            end
            if (s1_en)
            begin
                s1_valid_reg <= in_fire;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s4_valid_reg;
            end
            if (store_write)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_reg <= s1_next;
        end
        if (s2_en)
        begin
            s2_reg <= s2_next;
        end
        if (s3_en)
        begin
            s3_reg <= s3_next;
        end
        if (s4_en)
        begin
            s4_reg <= s3_reg;
        end
        if (store_write)
        begin
            fwd_addr_reg <= s4_reg.addr;
            fwd_data_reg <= new_byte;
        end
        if (out_ready)
        begin
            store_index_reg   <= store_index_next;
            byte_value_reg    <= byte_value_next;
            pixel_written_reg <= pixel_written_next;
            window_done_reg   <= s4_reg.done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign store_index   = store_index_reg;
    assign byte_value    = byte_value_reg;
    assign pixel_written = pixel_written_reg;
    assign window_done   = window_done_reg;

endmodule

`default_nettype wire

FILE: rtl/rdmp_ram.sv
// ----------------------------------------------------------------------------
// rdmp_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rdmp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8064
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rdmp_checker.sv
// ----------------------------------------------------------------------------
// rdmp_checker
// port-level checks of the mono packer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb565_dither_mono_packer_defines.svh"

module rdmp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [12:0] store_index,
    input wire logic [7:0]  byte_value,
    input wire logic        pixel_written,
    input wire logic        window_done
);

    // four pipeline stages plus the output register
    localparam logic [2:0] MAX_PENDING = 3'd5;
    localparam logic [12:0] STORE_LIM  = 13'(rdmp_pkg::STORE_BYTES);

    logic        in_accept;
    logic        out_accept;
    logic        out_beyond;
    logic [22:0] out_payload;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;

    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid && !out_stall;
    assign out_beyond  = out_valid && (store_index >= STORE_LIM);
    assign out_payload = {store_index, byte_value, pixel_written, window_done};

    // transactions accepted and not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_accept && !out_accept)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!in_accept && out_accept)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `RDMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

    `RDMP_ASSERT_IMPLY(a_out_of_store, out_beyond, (byte_value == 8'h00) && !pixel_written)

    `RDMP_ASSERT_IMPLY(a_no_invented, out_valid, pending_reg != 3'd0)

    `RDMP_ASSERT_IMPLY(a_bounded_pending, 1'b1, pending_reg <= MAX_PENDING)

endmodule

bind rgb565_dither_mono_packer rdmp_checker u_rdmp_checker (.*);

`default_nettype wire
